### hdl/pdf_pkg.sv
// Shared types, codes and defaults for the packet duplicate filter.
package pdf_pkg;

	localparam int ENTRIES_DEF    = 128;
	localparam int HASH_BYTES_DEF = 8;

	typedef enum logic [1:0] {
		FUNC_LOOKUP = 2'd0,
		FUNC_INSERT = 2'd1,
		FUNC_REMOVE = 2'd2,
		FUNC_RESET  = 2'd3
	} func_t;

	typedef struct packed {
		func_t       func;
		logic [63:0] packet_hash;
		logic        is_direct;
	} req_t;

	typedef struct packed {
		logic        seen;
		logic [31:0] direct_dup_count;
		logic [31:0] flood_dup_count;
	} result_t;

	typedef enum logic [1:0] {
		ST_CLEAR = 2'd0,
		ST_IDLE  = 2'd1,
		ST_EXEC  = 2'd2,
		ST_SCAN  = 2'd3
	} state_t;

	typedef struct packed {
		logic clear;
		logic load;
		logic scan_rd;
		logic finish;
	} cmd_t;

	typedef struct packed {
		func_t func;
		logic  hit;
		logic  scan_end;
		logic  clear_end;
	} status_t;

endpackage

### hdl/packet_duplicate_filter.sv
// Top level of the packet duplicate filter: a ring of recent packet hashes.
// After reset the block holds busy high while it writes zeros through the hash
// store, one entry per cycle. A request is taken when start is high and busy is
// low. Insert and counter reset finish in the EXEC state; lookup and remove read
// the store through its single read port one entry per cycle, in the EXEC and
// SCAN states, and stop at the first match or after the last entry. The result
// appears on result with done high for one cycle, in the first cycle with busy
// low again, and must be taken then: the block cannot hold it.
module packet_duplicate_filter #(
	parameter int ENTRIES    = pdf_pkg::ENTRIES_DEF,
	parameter int HASH_BYTES = pdf_pkg::HASH_BYTES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  pdf_pkg::req_t     req,
	output logic              busy,
	output logic              done,
	output pdf_pkg::result_t  result
);

	pdf_pkg::cmd_t    cmd;
	pdf_pkg::status_t status;

	pdf_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.status (status),
		.cmd    (cmd),
		.busy   (busy)
	);

	pdf_datapath #(
		.ENTRIES    (ENTRIES),
		.HASH_BYTES (HASH_BYTES)
	) u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cmd    (cmd),
		.status (status),
		.done   (done),
		.result (result)
	);

endmodule

### hdl/pdf_ram.sv
// Generic single-write, single-read RAM with registered read data.
module pdf_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### hdl/pdf_ctrl.sv
// Controller state machine for the packet duplicate filter.
module pdf_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  pdf_pkg::status_t  status,
	output pdf_pkg::cmd_t     cmd,
	output logic              busy
);

	pdf_pkg::state_t state_q;
	pdf_pkg::state_t state_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pdf_pkg::ST_CLEAR;
		end else begin
			state_q <= state_n;
		end
	end

	always_comb begin
		state_n = state_q;
		cmd     = '0;
		busy    = 1'b1;
		case (state_q)
			pdf_pkg::ST_CLEAR: begin
				cmd.clear = 1'b1;
				if (status.clear_end) begin
					state_n = pdf_pkg::ST_IDLE;
				end
			end
			pdf_pkg::ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.load = 1'b1;
					state_n  = pdf_pkg::ST_EXEC;
				end
			end
			pdf_pkg::ST_EXEC: begin
				if (status.func inside {pdf_pkg::FUNC_LOOKUP, pdf_pkg::FUNC_REMOVE}) begin
					cmd.scan_rd = 1'b1;
					state_n     = pdf_pkg::ST_SCAN;
				end else begin
					cmd.finish = 1'b1;
					state_n    = pdf_pkg::ST_IDLE;
				end
			end
			pdf_pkg::ST_SCAN: begin
				if (status.hit || status.scan_end) begin
					cmd.finish = 1'b1;
					state_n    = pdf_pkg::ST_IDLE;
				end else begin
					cmd.scan_rd = 1'b1;
				end
			end
			default: begin
				state_n = pdf_pkg::ST_CLEAR;
			end
		endcase
	end

endmodule

### hdl/pdf_datapath.sv
// Datapath: hash store, scan pipeline, ring pointer and duplicate counters.
module pdf_datapath #(
	parameter int ENTRIES    = pdf_pkg::ENTRIES_DEF,
	parameter int HASH_BYTES = pdf_pkg::HASH_BYTES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  pdf_pkg::req_t     req,
	input  pdf_pkg::cmd_t     cmd,
	output pdf_pkg::status_t  status,
	output logic              done,
	output pdf_pkg::result_t  result
);

	localparam int HW = 8 * HASH_BYTES;
	localparam int AW = $clog2(ENTRIES);
	localparam int CW = $clog2(ENTRIES + 1);
	localparam logic [CW-1:0] CNT_END  = CW'(ENTRIES);
	localparam logic [CW-1:0] CNT_LAST = CW'(ENTRIES - 1);
	localparam logic [AW-1:0] IDX_LAST = AW'(ENTRIES - 1);

	pdf_pkg::req_t    req_q;
	pdf_pkg::result_t result_q;
	logic             done_q;
	logic [CW-1:0]    cnt_q;
	logic [AW-1:0]    wp_q;
	logic [AW-1:0]    idx_s1;
	logic             valid_s1;
	logic [31:0]      direct_q;
	logic [31:0]      flood_q;

	logic             rd_en;
	logic [HW-1:0]    rd_data;
	logic             wr_en;
	logic [AW-1:0]    wr_addr;
	logic [HW-1:0]    wr_data;
	logic [HW-1:0]    key;
	logic             hit;
	logic             seen_n;
	logic [31:0]      direct_n;
	logic [31:0]      flood_n;

	assign key   = req_q.packet_hash[HW-1:0];
	assign rd_en = cmd.scan_rd && (cnt_q != CNT_END);
	assign hit   = valid_s1 && (rd_data == key);

	assign status.func      = req_q.func;
	assign status.hit       = hit;
	assign status.scan_end  = valid_s1 && (idx_s1 == IDX_LAST);
	assign status.clear_end = (cnt_q == CNT_LAST);

	always_comb begin
		wr_en    = 1'b0;
		wr_addr  = cnt_q[AW-1:0];
		wr_data  = '0;
		seen_n   = 1'b0;
		direct_n = direct_q;
		flood_n  = flood_q;
		if (cmd.clear) begin
			wr_en = 1'b1;
		end
		if (cmd.finish) begin
			case (req_q.func)
				pdf_pkg::FUNC_LOOKUP: begin
					seen_n = hit;
					if (hit) begin
						if (req_q.is_direct) begin
							direct_n = direct_q + 32'd1;
						end else begin
							flood_n = flood_q + 32'd1;
						end
					end
				end
				pdf_pkg::FUNC_INSERT: begin
					wr_en   = 1'b1;
					wr_addr = wp_q;
					wr_data = key;
				end
				pdf_pkg::FUNC_REMOVE: begin
					wr_en   = hit;
					wr_addr = idx_s1;
				end
				pdf_pkg::FUNC_RESET: begin
					direct_n = '0;
					flood_n  = '0;
				end
				default: begin
					seen_n = 1'b0;
				end
			endcase
		end
	end

	pdf_ram #(
		.WIDTH(HW),
		.DEPTH(ENTRIES)
	) u_store (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (wr_data),
		.re    (rd_en),
		.raddr (cnt_q[AW-1:0]),
		.rdata (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			wp_q     <= '0;
			valid_s1 <= 1'b0;
			direct_q <= '0;
			flood_q  <= '0;
			done_q   <= 1'b0;
		end else begin
			if (cmd.load) begin
				cnt_q <= '0;
			end else if (cmd.clear || rd_en) begin
				cnt_q <= cnt_q + CW'(1);
			end
			valid_s1 <= rd_en;
			done_q   <= cmd.finish;
			if (cmd.finish) begin
				direct_q <= direct_n;
				flood_q  <= flood_n;
				if (req_q.func == pdf_pkg::FUNC_INSERT) begin
					wp_q <= (wp_q == IDX_LAST) ? '0 : wp_q + AW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q <= req;
		end
		if (rd_en) begin
			idx_s1 <= cnt_q[AW-1:0];
		end
		if (cmd.finish) begin
			result_q.seen             <= seen_n;
			result_q.direct_dup_count <= direct_n;
			result_q.flood_dup_count  <= flood_n;
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

### hdl/pdf_checker.sv
// Port-level checker for the packet duplicate filter and its bind.
module pdf_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input logic              done,
	input pdf_pkg::result_t  result
);

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted request did not raise busy");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while still busy");

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result strobe without preceding work");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");

	a_result_known: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !$isunknown(result))
		else $error("result carries unknown bits");

endmodule

bind packet_duplicate_filter pdf_checker u_pdf_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.result (result)
);

### test/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for the packet duplicate filter: directed table, then random traffic.
module tb;

	localparam int DEPTH = pdf_pkg::ENTRIES_DEF;
	localparam int CYCLE_LIMIT = 600000;
	localparam logic [63:0] HASH_KEEP = (pdf_pkg::HASH_BYTES_DEF >= 8) ? {64{1'b1}} :
		((64'd1 << (8 * pdf_pkg::HASH_BYTES_DEF)) - 64'd1);
	localparam logic [63:0] ONES = {64{1'b1}};
	localparam logic [63:0] PATTERN = 64'h0123_4567_89ab_cdef;

	typedef struct packed {
		pdf_pkg::req_t    rq;
		logic             typed;
		pdf_pkg::result_t want;
	} stim_row_t;

	logic             clk = 1'b0;
	logic             arst_n;
	logic             start;
	pdf_pkg::req_t    req;
	logic             busy;
	logic             done;
	pdf_pkg::result_t result;

	logic             row_typed;
	pdf_pkg::result_t row_want;

	logic [63:0]      hash_ring [DEPTH];
	int unsigned      ring_ptr;
	logic [31:0]      direct_dups_m;
	logic [31:0]      flood_dups_m;
	pdf_pkg::result_t pending_results [$];
	logic [63:0]      recent_hashes [$];

	int unsigned mismatches = 0;
	int unsigned results_checked = 0;
	int unsigned watchdog = 0;
	int unsigned lookups = 0;
	int unsigned lookup_hits = 0;
	int unsigned inserts = 0;
	int unsigned removes = 0;
	int unsigned clears = 0;

	packet_duplicate_filter dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.req(req),
		.busy(busy),
		.done(done),
		.result(result)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	task automatic report_mismatch(string what);
		$display("MISMATCH at %0t ns: %s", $time, what);
		mismatches++;
	endtask

	function automatic pdf_pkg::result_t filter_step(pdf_pkg::req_t r);
		logic [63:0]      h;
		int               hit;
		int               i;
		pdf_pkg::result_t res;
		h = r.packet_hash & HASH_KEEP;
		hit = -1;
		res = '0;
		for (i = 0; i < DEPTH; i++) begin
			if (hit < 0 && hash_ring[i] == h) begin
				hit = i;
			end
		end
		case (r.func)
			pdf_pkg::FUNC_LOOKUP: begin
				if (hit >= 0) begin
					res.seen = 1'b1;
					if (r.is_direct) begin
						direct_dups_m = direct_dups_m + 32'd1;
					end else begin
						flood_dups_m = flood_dups_m + 32'd1;
					end
				end
			end
			pdf_pkg::FUNC_INSERT: begin
				hash_ring[ring_ptr] = h;
				ring_ptr = (ring_ptr + 1) % DEPTH;
			end
			pdf_pkg::FUNC_REMOVE: begin
				if (hit >= 0) begin
					hash_ring[hit] = '0;
				end
			end
			default: begin
				direct_dups_m = '0;
				flood_dups_m = '0;
			end
		endcase
		res.direct_dup_count = direct_dups_m;
		res.flood_dup_count = flood_dups_m;
		return res;
	endfunction

	always @(posedge clk) begin
		pdf_pkg::result_t want;
		if (arst_n === 1'b1) begin
			if (done === 1'b1) begin
				if (pending_results.size() == 0) begin
					report_mismatch("result strobe with no request outstanding");
				end else begin
					want = pending_results.pop_front();
					results_checked++;
					if (result.seen !== want.seen)
						report_mismatch($sformatf("seen %b, expected %b",
							result.seen, want.seen));
					if (result.direct_dup_count !== want.direct_dup_count)
						report_mismatch($sformatf("direct count %0d, expected %0d",
							result.direct_dup_count, want.direct_dup_count));
					if (result.flood_dup_count !== want.flood_dup_count)
						report_mismatch($sformatf("flood count %0d, expected %0d",
							result.flood_dup_count, want.flood_dup_count));
				end
			end
			if (start === 1'b1 && busy === 1'b0) begin
				want = filter_step(req);
				case (req.func)
					pdf_pkg::FUNC_LOOKUP: begin
						lookups++;
						if (want.seen) lookup_hits++;
					end
					pdf_pkg::FUNC_INSERT: inserts++;
					pdf_pkg::FUNC_REMOVE: removes++;
					default: clears++;
				endcase
				if (row_typed) begin
					pending_results.push_back(row_want);
				end else begin
					pending_results.push_back(want);
				end
			end
		end
	end

	always @(posedge clk) begin
		watchdog++;
		if (watchdog == CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles with %0d results outstanding.",
				watchdog, pending_results.size());
			$display("CHECKS FAILED");
			$finish;
		end
	end

	task automatic issue(pdf_pkg::req_t r, logic typed, pdf_pkg::result_t want,
			int idle_pct);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		req <= r;
		row_typed <= typed;
		row_want <= want;
		do @(posedge clk); while (busy !== 1'b0);
	endtask

	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	function automatic stim_row_t stim_row(pdf_pkg::func_t f, logic [63:0] h, logic d,
			logic typed, logic s, logic [31:0] dc, logic [31:0] fc);
		stim_row_t row;
		row.rq.func = f;
		row.rq.packet_hash = h;
		row.rq.is_direct = d;
		row.typed = typed;
		row.want.seen = s;
		row.want.direct_dup_count = dc;
		row.want.flood_dup_count = fc;
		return row;
	endfunction

	function automatic pdf_pkg::req_t random_request();
		pdf_pkg::req_t r;
		int            pick;
		pick = $urandom_range(99);
		if (pick < 40) r.func = pdf_pkg::FUNC_LOOKUP;
		else if (pick < 72) r.func = pdf_pkg::FUNC_INSERT;
		else if (pick < 95) r.func = pdf_pkg::FUNC_REMOVE;
		else r.func = pdf_pkg::FUNC_RESET;
		pick = $urandom_range(99);
		if (pick < 55 && recent_hashes.size() > 0)
			r.packet_hash = recent_hashes[$urandom_range(recent_hashes.size() - 1)];
		else if (pick < 60)
			r.packet_hash = '0;
		else
			r.packet_hash = {$urandom, $urandom};
		r.is_direct = 1'($urandom_range(1));
		if (r.func == pdf_pkg::FUNC_INSERT) begin
			recent_hashes.push_back(r.packet_hash);
			if (recent_hashes.size() > 160) void'(recent_hashes.pop_front());
		end
		return r;
	endfunction

	initial begin
		stim_row_t directed [$];
		int        idle_plan [3];
		int        phase_items [3];
		int        p;
		int        n;

		idle_plan = '{31, 45, 0};
		phase_items = '{240, 240, 220};
		arst_n = 1'b0;
		start = 1'b0;
		req = '0;
		row_typed = 1'b0;
		row_want = '0;
		for (n = 0; n < DEPTH; n++) hash_ring[n] = '0;
		ring_ptr = 0;
		direct_dups_m = '0;
		flood_dups_m = '0;

		// The store is all zero after reset, so a zero hash already counts as seen.
		directed.push_back(stim_row(pdf_pkg::FUNC_LOOKUP, '0, 1'b0, 1'b1, 1'b1, 0, 1));
		directed.push_back(stim_row(pdf_pkg::FUNC_LOOKUP, '0, 1'b1, 1'b1, 1'b1, 1, 1));
		directed.push_back(stim_row(pdf_pkg::FUNC_RESET, '0, 1'b0, 1'b1, 1'b0, 0, 0));
		directed.push_back(stim_row(pdf_pkg::FUNC_LOOKUP, ONES, 1'b1, 1'b1, 1'b0, 0, 0));
		directed.push_back(stim_row(pdf_pkg::FUNC_INSERT, ONES, 1'b0, 1'b1, 1'b0, 0, 0));
		directed.push_back(stim_row(pdf_pkg::FUNC_LOOKUP, ONES, 1'b1, 1'b1, 1'b1, 1, 0));
		directed.push_back(stim_row(pdf_pkg::FUNC_REMOVE, ONES, 1'b1, 1'b1, 1'b0, 1, 0));
		directed.push_back(stim_row(pdf_pkg::FUNC_LOOKUP, ONES, 1'b0, 1'b1, 1'b0, 1, 0));
		directed.push_back(stim_row(pdf_pkg::FUNC_REMOVE, 64'h1234, 1'b0, 1'b1,
			1'b0, 1, 0));
		// Two copies of one hash: a lookup counts once, a remove clears one copy.
		directed.push_back(stim_row(pdf_pkg::FUNC_INSERT, PATTERN, 1'b0, 1'b1,
			1'b0, 1, 0));
		directed.push_back(stim_row(pdf_pkg::FUNC_INSERT, PATTERN, 1'b1, 1'b1,
			1'b0, 1, 0));
		directed.push_back(stim_row(pdf_pkg::FUNC_LOOKUP, PATTERN, 1'b0, 1'b1,
			1'b1, 1, 1));
		directed.push_back(stim_row(pdf_pkg::FUNC_REMOVE, PATTERN, 1'b0, 1'b1,
			1'b0, 1, 1));
		directed.push_back(stim_row(pdf_pkg::FUNC_LOOKUP, PATTERN, 1'b0, 1'b1,
			1'b1, 1, 2));
		directed.push_back(stim_row(pdf_pkg::FUNC_REMOVE, PATTERN, 1'b0, 1'b1,
			1'b0, 1, 2));
		directed.push_back(stim_row(pdf_pkg::FUNC_LOOKUP, PATTERN, 1'b1, 1'b1,
			1'b0, 1, 2));
		directed.push_back(stim_row(pdf_pkg::FUNC_INSERT, 64'h1, 1'b0, 1'b1,
			1'b0, 1, 2));
		directed.push_back(stim_row(pdf_pkg::FUNC_INSERT, 64'h8000_0000_0000_0000,
			1'b0, 1'b1, 1'b0, 1, 2));
		directed.push_back(stim_row(pdf_pkg::FUNC_LOOKUP, 64'h1, 1'b1, 1'b1,
			1'b1, 2, 2));
		directed.push_back(stim_row(pdf_pkg::FUNC_LOOKUP, 64'h8000_0000_0000_0000,
			1'b0, 1'b1, 1'b1, 2, 3));
		directed.push_back(stim_row(pdf_pkg::FUNC_RESET, ONES, 1'b1, 1'b1, 1'b0, 0, 0));
		directed.push_back(stim_row(pdf_pkg::FUNC_LOOKUP, '0, 1'b0, 1'b1, 1'b1, 0, 1));
		directed.push_back(stim_row(pdf_pkg::FUNC_INSERT, 64'haaaa_aaaa_aaaa_aaaa,
			1'b1, 1'b0, 1'b0, 0, 0));
		directed.push_back(stim_row(pdf_pkg::FUNC_LOOKUP, 64'h5555_5555_5555_5555,
			1'b1, 1'b0, 1'b0, 0, 0));

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		foreach (directed[i]) begin
			issue(directed[i].rq, directed[i].typed, directed[i].want, 0);
		end

		for (p = 0; p < 3; p++) begin
			drain();
			for (n = 0; n < phase_items[p]; n++) begin
				issue(random_request(), 1'b0, '0, idle_plan[p]);
			end
		end

		drain();
		repeat (DEPTH + 8) @(posedge clk);
		if (pending_results.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", pending_results.size()));
		$display("Exercised %0d lookups (%0d hits), %0d inserts, %0d removes, %0d clears.",
			lookups, lookup_hits, inserts, removes, clears);
		$display("Compared %0d results over a directed table and three idle mixes.",
			results_checked);
		if (mismatches == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
